@@ rtl/dfsam_pkg.sv @@
// shared constants and action codes for the depth-first traversal core
`default_nettype none
package dfsam_pkg;
	localparam int DEF_MAX_NODES = 64;
	localparam int NODE_W = 6;
	localparam int COUNT_W = 7;
	localparam logic [COUNT_W-1:0] DEF_NODE_COUNT = 7'd64;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_ADD = 2'd1;
	localparam logic [1:0] ACT_RUN = 2'd2;
endpackage
`default_nettype wire

@@ rtl/dfsam_pick.sv @@
// lowest-index priority pick over a candidate neighbor vector
`default_nettype none
module dfsam_pick
	import dfsam_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  wire logic [MAX_NODES-1:0]         cand,
	output logic                              found,
	output logic [$clog2(MAX_NODES)-1:0]      idx
);
	localparam int NW = $clog2(MAX_NODES);

	always_comb begin
		found = 1'b0;
		idx = '0;
		for (int i = MAX_NODES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				found = 1'b1;
				idx = NW'(i);
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/dfs_adjacency_matrix_traversal_core.sv @@
// top level of the depth-first adjacency-matrix traversal core
`default_nettype none
// usage:
// - one request is taken on a rising edge with start high and busy low;
//   action picks clear-all-edges, add-edge (from_node -> to_node) or run
// - clear stays idle; add is a read-modify-write of one row (write in ST_ADD_WR)
// - a run from from_node emits each newly visited node on visited_node,
//   one per result_valid pulse, lowest-index unvisited neighbor first;
//   last marks the final node of the run
// - a run holds busy through an ST_EVAL step for each push, a pop for each
//   step back (dead-end check with stack memory read, then adjacency row
//   read in ST_POP) and one final dead-end check; the adjacency memory is
//   read synchronously, and the next request can be taken once busy drops
// - the first result is registered from the first ST_EVAL step, the last one
//   on the cycle busy drops
// - results are one-cycle strobes; the receiver cannot hold them off
// - cfg_we writes node_count; write only while busy is low (not enforced by
//   the block); 0 acts as 1, values above MAX_NODES act as MAX_NODES
// - reset clears all edges at once (per-row valid bits), the stack and the
//   node count returns to 64; no clearing pass is needed
module dfs_adjacency_matrix_traversal_core
	import dfsam_pkg::*;
#(
	parameter int MAX_NODES = DEF_MAX_NODES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         action,
	input  wire logic [NODE_W-1:0]  from_node,
	input  wire logic [NODE_W-1:0]  to_node,
	input  wire logic               cfg_we,
	input  wire logic [COUNT_W-1:0] cfg_data,
	output logic                    result_valid,
	output logic [NODE_W-1:0]       visited_node,
	output logic                    last
);
	localparam int NW = $clog2(MAX_NODES);
	localparam int DW = $clog2(MAX_NODES + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADD_WR = 2'd1;
	localparam logic [1:0] ST_EVAL = 2'd2;
	localparam logic [1:0] ST_POP = 2'd3;

	logic [1:0] state_q;
	logic [COUNT_W-1:0] node_count_q;
	logic [COUNT_W-1:0] n_eff;
	logic [MAX_NODES-1:0] n_mask;

	// adjacency rows in a synchronous memory, valid bit per row in flops
	logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
	logic [MAX_NODES-1:0] row_vld_q;
	logic [MAX_NODES-1:0] adj_rd_q;
	logic adj_vld_q;
	logic adj_re, adj_we;
	logic [NW-1:0] adj_ra;
	logic [MAX_NODES-1:0] adj_wd;
	logic [MAX_NODES-1:0] row_eff;

	// node stack memory, read port registered in stk_rd_q
	logic [NW-1:0] stk_mem [MAX_NODES];
	logic [NW-1:0] stk_rd_q;
	logic stk_re, stk_we;
	logic [NW-1:0] stk_wd;

	logic [DW-1:0] depth_q;
	logic [DW-1:0] depth_m2;
	logic [MAX_NODES-1:0] visited_q;
	logic [NW-1:0] from_q, to_q;

	// held result: its last flag is known only when the next step resolves
	logic [NW-1:0] pend_q;

	logic res_valid_q, res_last_q;
	logic [NW-1:0] res_node_q;

	logic accept;
	logic from_ok, to_ok;
	logic [MAX_NODES-1:0] cand;
	logic nxt_found;
	logic [NW-1:0] nxt_idx;

	// effective node count and in-graph mask
	always_comb begin
		if (node_count_q == '0) begin
			n_eff = COUNT_W'(1);
		end else if (node_count_q > COUNT_W'(MAX_NODES)) begin
			n_eff = COUNT_W'(MAX_NODES);
		end else begin
			n_eff = node_count_q;
		end
		for (int i = 0; i < MAX_NODES; i++) begin
			n_mask[i] = COUNT_W'(i) < n_eff;
		end
	end

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign from_ok = COUNT_W'(from_node) < n_eff;
	assign to_ok = COUNT_W'(to_node) < n_eff;

	assign row_eff = adj_vld_q ? adj_rd_q : '0;
	assign cand = row_eff & ~visited_q & n_mask;
	assign depth_m2 = depth_q - DW'(2);

	dfsam_pick #(
		.MAX_NODES(MAX_NODES)
	) u_pick (
		.cand (cand),
		.found(nxt_found),
		.idx  (nxt_idx)
	);

	// memory port control
	always_comb begin
		adj_re = 1'b0;
		adj_ra = from_node[NW-1:0];
		adj_we = 1'b0;
		adj_wd = row_eff | (MAX_NODES'(1) << to_q);
		stk_re = 1'b0;
		stk_we = 1'b0;
		stk_wd = nxt_idx;
		case (state_q)
			ST_IDLE: begin
				if (accept && from_ok && (action == ACT_RUN ||
					(action == ACT_ADD && to_ok))) begin
					adj_re = 1'b1;
				end
				if (accept && from_ok && action == ACT_RUN) begin
					stk_we = 1'b1;
					stk_wd = from_node[NW-1:0];
				end
			end
			ST_ADD_WR: begin
				adj_we = 1'b1;
			end
			ST_EVAL: begin
				if (nxt_found) begin
					adj_re = 1'b1;
					adj_ra = nxt_idx;
					stk_we = 1'b1;
				end else if (depth_q > DW'(1)) begin
					stk_re = 1'b1;
				end
			end
			ST_POP: begin
				adj_re = 1'b1;
				adj_ra = stk_rd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[from_q] <= adj_wd;
		end
		if (adj_re) begin
			adj_rd_q <= adj_mem[adj_ra];
		end
	end

	// stack write at depth, pop reads the entry below the top
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[(state_q == ST_IDLE) ? '0 : depth_q[NW-1:0]] <= stk_wd;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[depth_m2[NW-1:0]];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			node_count_q <= DEF_NODE_COUNT;
			row_vld_q <= '0;
			adj_vld_q <= 1'b0;
			depth_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_we) begin
				node_count_q <= cfg_data;
			end
			if (adj_re) begin
				adj_vld_q <= row_vld_q[adj_ra];
			end
			if (adj_we) begin
				row_vld_q[from_q] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (action)
							ACT_CLEAR: row_vld_q <= '0;
							ACT_ADD: begin
								if (from_ok && to_ok) begin
									state_q <= ST_ADD_WR;
								end
							end
							ACT_RUN: begin
								if (from_ok) begin
									state_q <= ST_EVAL;
									depth_q <= DW'(1);
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ADD_WR: state_q <= ST_IDLE;
				ST_EVAL: begin
					if (nxt_found) begin
						depth_q <= depth_q + DW'(1);
						res_valid_q <= 1'b1;
					end else if (depth_q > DW'(1)) begin
						depth_q <= depth_q - DW'(1);
						state_q <= ST_POP;
					end else begin
						// stack empties: flush the held node as the last one
						depth_q <= '0;
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_POP: state_q <= ST_EVAL;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				from_q <= from_node[NW-1:0];
				to_q <= to_node[NW-1:0];
				if (accept && action == ACT_RUN) begin
					visited_q <= MAX_NODES'(1) << from_node[NW-1:0];
					pend_q <= from_node[NW-1:0];
				end
			end
			ST_EVAL: begin
				res_node_q <= pend_q;
				res_last_q <= !nxt_found;
				if (nxt_found) begin
					visited_q <= visited_q | (MAX_NODES'(1) << nxt_idx);
					pend_q <= nxt_idx;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = res_valid_q;
	assign visited_node = NODE_W'(res_node_q);
	assign last = res_last_q;
endmodule
`default_nettype wire

@@ test/dfs_adjacency_matrix_traversal_core_tb.sv @@
// self-checking testbench for the depth-first adjacency-matrix traversal core
module dfs_adjacency_matrix_traversal_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfsam_pkg::*;

	localparam int MAX_N = DEF_MAX_NODES;
	localparam int NUM_ITEMS = 370;
	// quiet cycles with nothing outstanding before a register write or a drain completes
	localparam int SETTLE_CYCLES = 8;
	// sized from MAX_N so this covers the slowest run
	localparam int TAIL_CYCLES = 3 * MAX_N + 16;
	localparam int TIMEOUT_NS = 5_000_000;
	localparam int MAX_REPORTS = 10;
	// action code that the block has to ignore
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		STEP_REQ,
		STEP_CFG,
		STEP_DRAIN
	} step_kind_t;

	// one entry of the stimulus queue: a request, a node count write or a drain pause
	typedef struct {
		step_kind_t             kind;
		logic [1:0]             action;
		logic [NODE_W-1:0]      from_node;
		logic [NODE_W-1:0]      to_node;
		logic [COUNT_W-1:0]     count;
		int                     gap_pct;
	} step_t;

	typedef struct {
		logic [NODE_W-1:0] node;
		logic              last;
	} visit_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         action = ACT_CLEAR;
	logic [NODE_W-1:0]  from_node = '0;
	logic [NODE_W-1:0]  to_node = '0;
	logic               cfg_we = 1'b0;
	logic [COUNT_W-1:0] cfg_data = '0;
	logic               result_valid;
	logic [NODE_W-1:0]  visited_node;
	logic               last;

	// pending stimulus and the visits still owed by the block
	step_t  step_q[$];
	visit_t visit_q[$];
	step_t  cur_req;

	// shadow copy of the block's state and its node count register
	logic [MAX_N-1:0]   arc_rows [MAX_N];
	logic [COUNT_W-1:0] node_count_shadow = DEF_NODE_COUNT;

	int mismatch_cnt = 0;
	int quiet_cnt = 0;
	int counted_items = 0;

	dfs_adjacency_matrix_traversal_core #(
		.MAX_NODES(MAX_N)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.from_node(from_node),
		.to_node(to_node),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.visited_node(visited_node),
		.last(last)
	);

	always #5 clk = ~clk;

	// 0 acts as one node, anything above the matrix size acts as the full matrix
	function automatic int active_nodes(logic [COUNT_W-1:0] v);
		if (v == 0) begin
			return 1;
		end
		if (int'(v) > MAX_N) begin
			return MAX_N;
		end
		return int'(v);
	endfunction

	// apply one accepted request to the shadow state and queue the visits it should emit
	function automatic void predict_visits(step_t r);
		int i;
		int n;
		int depth;
		int cnt;
		int top;
		int nxt;
		logic [MAX_N-1:0]  seen;
		logic [MAX_N-1:0]  cand;
		logic [NODE_W-1:0] stk [MAX_N];
		logic [NODE_W-1:0] order [MAX_N];
		visit_t v;
		n = active_nodes(node_count_shadow);
		case (r.action)
			ACT_CLEAR: begin
				for (i = 0; i < MAX_N; i++) begin
					arc_rows[i] = '0;
				end
			end
			ACT_ADD: begin
				// arcs with either end outside the graph are dropped
				if (int'(r.from_node) < n && int'(r.to_node) < n) begin
					arc_rows[r.from_node][r.to_node] = 1'b1;
				end
			end
			ACT_RUN: begin
				if (int'(r.from_node) < n) begin
					seen = '0;
					seen[r.from_node] = 1'b1;
					stk[0] = r.from_node;
					depth = 1;
					order[0] = r.from_node;
					cnt = 1;
					while (depth > 0) begin
						top = int'(stk[depth-1]);
						cand = arc_rows[top] & ~seen;
						nxt = n;
						for (i = 0; i < n; i++) begin
							if (cand[i] && nxt == n) begin
								nxt = i;
							end
						end
						if (nxt < n) begin
							// descend into the lowest unvisited neighbor
							seen[nxt] = 1'b1;
							stk[depth] = NODE_W'(nxt);
							depth++;
							order[cnt] = NODE_W'(nxt);
							cnt++;
						end else begin
							// dead end: back up one level
							depth--;
						end
					end
					for (i = 0; i < cnt; i++) begin
						v.node = order[i];
						v.last = (i == cnt - 1);
						visit_q.push_back(v);
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	// sender idling by phase: none, heavy, none, light
	function automatic int phase_gap();
		int p;
		p = (counted_items * 4) / NUM_ITEMS;
		case (p)
			0: begin
				return 0;
			end
			1: begin
				return 73;
			end
			2: begin
				return 0;
			end
			default: begin
				return 26;
			end
		endcase
	endfunction

	task automatic push_req(logic [1:0] act, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
			bit counts);
		step_t s;
		s.kind = STEP_REQ;
		s.action = act;
		s.from_node = src;
		s.to_node = dst;
		s.count = '0;
		s.gap_pct = phase_gap();
		step_q.push_back(s);
		if (counts) begin
			counted_items++;
		end
	endtask

	task automatic push_ctrl(step_kind_t kind, logic [COUNT_W-1:0] value);
		step_t s;
		s.kind = kind;
		s.action = ACT_CLEAR;
		s.from_node = '0;
		s.to_node = '0;
		s.count = value;
		s.gap_pct = 0;
		step_q.push_back(s);
	endtask

	// driver: presents requests, and writes the node count only once the block has gone quiet
	always @(posedge clk or negedge arst_n) begin : drive_requests
		step_t nxt_step;
		logic  start_nx;
		logic  we_nx;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_we <= 1'b0;
			quiet_cnt = 0;
		end else begin
			start_nx = start;
			we_nx = 1'b0;
			// quiet means nothing in flight and nothing owed; quiet_cnt measures how long that has held
			if (!start && !cfg_we && !busy && visit_q.size() == 0) begin
				quiet_cnt++;
			end else begin
				quiet_cnt = 0;
			end
			if (start && !busy) begin
				// request taken at this edge
				predict_visits(cur_req);
				start_nx = 1'b0;
			end
			if (!start_nx && step_q.size() != 0) begin
				nxt_step = step_q[0];
				if (nxt_step.kind == STEP_REQ) begin
					if ($urandom_range(99) >= nxt_step.gap_pct) begin
						void'(step_q.pop_front());
						cur_req = nxt_step;
						action <= nxt_step.action;
						from_node <= nxt_step.from_node;
						to_node <= nxt_step.to_node;
						start_nx = 1'b1;
					end
				end else if (quiet_cnt >= SETTLE_CYCLES) begin
					void'(step_q.pop_front());
					if (nxt_step.kind == STEP_CFG) begin
						cfg_data <= nxt_step.count;
						we_nx = 1'b1;
						node_count_shadow = nxt_step.count;
					end
					quiet_cnt = 0;
				end
			end
			start <= start_nx;
			cfg_we <= we_nx;
		end
	end

	// monitor: every strobe must match the oldest owed visit
	always @(posedge clk) begin : check_visits
		visit_t exp_v;
		if (arst_n && result_valid) begin
			if (visit_q.size() == 0) begin
				if (mismatch_cnt < MAX_REPORTS) begin
					$display("%0t unexpected visit: node %0d last %0d", $realtime,
						visited_node, last);
				end
				mismatch_cnt++;
			end else begin
				exp_v = visit_q.pop_front();
				if (visited_node !== exp_v.node || last !== exp_v.last) begin
					if (mismatch_cnt < MAX_REPORTS) begin
						$display("%0t visit mismatch: expected node %0d last %0d, got node %0d last %0d",
							$realtime, exp_v.node, exp_v.last, visited_node, last);
					end
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin : stimulus
		int i;
		int j;
		int k;
		int gen_n;
		int n_arcs;
		int n_runs;
		int sel;
		logic [COUNT_W-1:0] cnt_val;
		logic [NODE_W-1:0]  perm [MAX_N];
		logic [NODE_W-1:0]  tmp;
		for (i = 0; i < MAX_N; i++) begin
			arc_rows[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty graph, both ends of the node range, self loop, repeated arc
		push_req(ACT_RUN, 6'd0, 6'd0, 1);
		push_req(ACT_RUN, 6'd63, 6'd0, 1);
		push_req(ACT_ADD, 6'd0, 6'd63, 1);
		push_req(ACT_ADD, 6'd63, 6'd0, 1);
		push_req(ACT_ADD, 6'd0, 6'd63, 1);
		push_req(ACT_ADD, 6'd5, 6'd5, 1);
		push_req(ACT_RUN, 6'd0, 6'd0, 1);
		push_req(ACT_RUN, 6'd5, 6'd0, 1);
		// unused action code must be ignored
		push_req(ACT_UNUSED, 6'd21, 6'd42, 1);
		push_req(ACT_CLEAR, 6'd0, 6'd0, 1);
		push_req(ACT_RUN, 6'd63, 6'd0, 1);
		// three nodes: arcs leaving the graph are dropped, start outside emits nothing
		push_ctrl(STEP_CFG, 7'd3);
		push_req(ACT_ADD, 6'd2, 6'd5, 1);
		push_req(ACT_ADD, 6'd0, 6'd1, 1);
		push_req(ACT_ADD, 6'd1, 6'd2, 1);
		push_req(ACT_ADD, 6'd2, 6'd0, 1);
		push_req(ACT_RUN, 6'd0, 6'd0, 1);
		push_req(ACT_RUN, 6'd5, 6'd0, 1);
		// zero acts as a single node
		push_ctrl(STEP_CFG, 7'd0);
		push_req(ACT_RUN, 6'd0, 6'd0, 1);
		push_req(ACT_RUN, 6'd1, 6'd0, 1);
		// above the matrix size acts as the full matrix
		push_ctrl(STEP_CFG, 7'd127);
		push_req(ACT_ADD, 6'd1, 6'd63, 1);
		push_req(ACT_RUN, 6'd2, 6'd0, 1);
		push_ctrl(STEP_DRAIN, '0);

		// first random episode: a full 64-node chain, deepest stack and most visits
		push_ctrl(STEP_CFG, 7'd64);
		gen_n = MAX_N;
		push_req(ACT_CLEAR, '0, '0, 1);
		for (i = 0; i < MAX_N; i++) begin
			perm[i] = NODE_W'(i);
		end
		for (i = MAX_N - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		for (i = 0; i < MAX_N - 1; i++) begin
			push_req(ACT_ADD, perm[i], perm[i+1], 1);
		end
		push_req(ACT_RUN, perm[0], '0, 1);
		push_req(ACT_RUN, NODE_W'($urandom_range(MAX_N - 1)), '0, 1);

		while (counted_items < NUM_ITEMS) begin
			if ($urandom_range(99) < 25) begin
				sel = $urandom_range(9);
				if (sel < 5) begin
					cnt_val = COUNT_W'($urandom_range(8, 1));
				end else if (sel < 7) begin
					cnt_val = COUNT_W'($urandom_range(MAX_N, 9));
				end else if (sel == 7) begin
					cnt_val = COUNT_W'(MAX_N);
				end else begin
					cnt_val = COUNT_W'($urandom_range(127));
				end
				push_ctrl(STEP_CFG, cnt_val);
				gen_n = active_nodes(cnt_val);
			end
			if ($urandom_range(3) != 0) begin
				push_req(ACT_CLEAR, NODE_W'($urandom), NODE_W'($urandom), 1);
			end
			if ($urandom_range(9) == 0) begin
				// chain through all active nodes in shuffled order
				for (i = 0; i < gen_n; i++) begin
					perm[i] = NODE_W'(i);
				end
				for (i = gen_n - 1; i > 0; i--) begin
					j = $urandom_range(i);
					tmp = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
				end
				for (i = 0; i < gen_n - 1; i++) begin
					push_req(ACT_ADD, perm[i], perm[i+1], 1);
				end
			end else begin
				n_arcs = $urandom_range((gen_n > 16) ? 40 : 2 * gen_n);
				for (k = 0; k < n_arcs; k++) begin
					if ($urandom_range(9) == 0) begin
						// noise: unused action or arcs with arbitrary ends
						if ($urandom_range(1) == 0) begin
							push_req(ACT_UNUSED, NODE_W'($urandom), NODE_W'($urandom), 1);
						end else begin
							push_req(ACT_ADD, NODE_W'($urandom), NODE_W'($urandom), 1);
						end
					end else begin
						push_req(ACT_ADD, NODE_W'($urandom_range(gen_n - 1)),
							NODE_W'($urandom_range(gen_n - 1)), 1);
					end
				end
			end
			n_runs = $urandom_range(3, 1);
			for (k = 0; k < n_runs; k++) begin
				if ($urandom_range(7) == 0) begin
					push_req(ACT_RUN, NODE_W'($urandom), NODE_W'($urandom), 1);
				end else begin
					push_req(ACT_RUN, NODE_W'($urandom_range(gen_n - 1)), NODE_W'($urandom), 1);
				end
			end
			// hold the sender off until the block has emitted everything owed
			if ($urandom_range(9) == 0) begin
				push_ctrl(STEP_DRAIN, '0);
			end
		end

		// sampled on the falling edge so the driver's updates have settled
		while (step_q.size() != 0 || start || busy || visit_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && visit_q.size() == 0) begin
			$display("dfs_adjacency_matrix_traversal_core: match");
		end else begin
			$display("dfs_adjacency_matrix_traversal_core: mismatch");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("dfs_adjacency_matrix_traversal_core: mismatch");
		$finish;
	end
endmodule
